FILE: hdl/ectl_pkg.sv
// Shared constants, types and helper functions for the exponential cohesive traction pipeline.
// No dependencies; every module of the block imports this package.
package ectl_pkg;

	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS  = 55;
	localparam int TAY_TERMS  = 20;
	localparam int POW_STEPS  = 17;
	localparam int EXP_LIMIT  = 18;

	localparam logic [24:0] ONE_Q24  = 25'd16777216;
	localparam logic [30:0] ONE_Q30  = 31'd1073741824;
	localparam logic [62:0] SUM_CAP  = 63'd4611686018427387904;
	localparam logic [55:0] PREF_CAP = 56'd36028797018963968;
	localparam logic [31:0] MAX31    = 32'd2147483647;
	localparam logic [31:0] MIN_MAG  = 32'h8000_0000;

	typedef enum logic [2:0] {
		CFG_FRACTURE_ENERGY   = 3'd0,
		CFG_SOFTENING_LENGTH  = 3'd1,
		CFG_TANGENTIAL_WEIGHT = 3'd2,
		CFG_IRREVERSIBLE_MODE = 3'd3,
		CFG_NORM_REGULARIZER  = 3'd4
	} cfg_index_t;

	// Per-item data that travels down the whole pipeline.
	typedef struct packed {
		logic signed [31:0] n;
		logic signed [31:0] ta;
		logic signed [31:0] tb;
		logic [30:0]        om;
		logic [30:0]        h;
		logic [31:0]        sb;
		logic [29:0]        f;
		logic [4:0]         ipow;
		logic               big;
		logic [24:0]        damage;
		logic               sat;
	} carry_t;

	// floor(2^32 / k), an underestimate of the reciprocal for the Taylor divides.
	localparam logic [32:0] RECIP [1:20] = '{
		33'd4294967296, 33'd2147483648, 33'd1431655765, 33'd1073741824, 33'd858993459,
		33'd715827882,  33'd613566756,  33'd536870912,  33'd477218588,  33'd429496729,
		33'd390451572,  33'd357913941,  33'd330382099,  33'd306783378,  33'd286331153,
		33'd268435456,  33'd252645135,  33'd238609294,  33'd226050910,  33'd214748364
	};

	// exp(-1) in Q2.30 as the same truncating 20-term series evaluates it.
	localparam logic [30:0] E1_Q30 = 31'd395007543;

	function automatic logic [31:0] abs32(input logic signed [31:0] v);
		return v[31] ? 32'(-v) : 32'(v);
	endfunction

	// Finish sign(v) * floor(|v|*q / 2^24) from the two partial products.
	function automatic logic [31:0] scale_fin(input logic [55:0] hi, input logic [63:0] lo,
			input logic neg);
		logic [62:0] r;
		logic [31:0] m;
		r = 63'({hi[53:0], 8'b0}) + 63'(lo[63:24]);
		if (hi >= 56'(64'd1 << 54))
			m = MIN_MAG;
		else if (r > 63'(MIN_MAG))
			m = MIN_MAG;
		else
			m = r[31:0];
		if (neg)
			return 32'(-m);
		return (m > MAX31) ? MAX31 : m;
	endfunction

endpackage

FILE: hdl/exp_cohesive_traction_law.sv
// Top level of the exponential cohesive traction-separation pipeline.
// Depends on ectl_pkg, ectl_isqrt and ectl_div.
//
// One material point enters per clock and results leave in the same order; the
// block sustains one item per cycle for as long as the output side takes items.
// The pipeline is built from serial arithmetic: two 32-stage square roots run side
// by side (effective jump and sqrt(beta)), then three 55-stage restoring dividers
// in series with a 60-stage truncating Taylor series and 17 power stages for the
// exponential in between. The whole pipeline advances together; when a finished
// item waits at the output and the consumer is not ready, every stage holds.
// Configuration registers are read live by the stages, so they must only be
// written while no item is in flight. There is no clearing pass after reset.
module exp_cohesive_traction_law import ectl_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [31:0] normal_jump, [63:32] tangent_jump_a, [95:64] tangent_jump_b,
	// [126:96] old_max_effective, [127] zero
	input  logic [127:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [31:0] traction_normal, [63:32] traction_tangent_a, [95:64] traction_tangent_b,
	// [120:96] damage_value, [151:121] new_max_effective, [183:152] effective_normal,
	// [215:184] effective_tangent_a, [247:216] effective_tangent_b
	output logic [247:0] m_axis_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	// Stage numbers: register stage k is the k-th register the item passes after acceptance.
	localparam int ST_SUM = 5;
	localparam int ST_H   = ST_SUM + SQRT_STEPS + 1;
	localparam int ST_X   = ST_H + DIV_STEPS;
	localparam int ST_TY0 = ST_X + 1;
	localparam int ST_TYE = ST_TY0 + 3*TAY_TERMS;
	localparam int ST_CL  = ST_TYE + 1;
	localparam int ST_PWE = ST_CL + POW_STEPS;
	localparam int ST_E   = ST_PWE + 1;
	localparam int ST_P   = ST_E + 1;
	localparam int ST_Q1  = ST_P + DIV_STEPS;
	localparam int ST_Q   = ST_Q1 + DIV_STEPS;
	localparam int ST_MUL = ST_Q + 1;
	localparam int ST_OUT = ST_MUL + 1;

	// Configuration registers.
	logic [30:0] fe_q;
	logic [30:0] d0_q;
	logic [30:0] tw_q;
	logic        irr_q;
	logic [7:0]  eps_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fe_q  <= 31'(ONE_Q24);
			d0_q  <= 31'(ONE_Q24);
			tw_q  <= 31'(ONE_Q24);
			irr_q <= 1'b1;
			eps_q <= 8'd0;
		end else if (cfg_valid) begin
			case (cfg_index_t'(cfg_index))
				CFG_FRACTURE_ENERGY: begin
					fe_q <= cfg_data[30:0];
				end
				CFG_SOFTENING_LENGTH: begin
					// A zero softening length behaves as one LSB.
					d0_q <= (cfg_data[30:0] == 31'd0) ? 31'd1 : cfg_data[30:0];
				end
				CFG_TANGENTIAL_WEIGHT: begin
					tw_q <= cfg_data[30:0];
				end
				CFG_IRREVERSIBLE_MODE: begin
					irr_q <= cfg_data[0];
				end
				CFG_NORM_REGULARIZER: begin
					eps_q <= cfg_data[7:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Flow control: the whole pipeline moves unless the output item is stuck.
	logic en;
	logic vld_s [1:ST_OUT];

	assign en            = !vld_s[ST_OUT] || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_s[ST_OUT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= ST_OUT; k++)
				vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[1] <= s_axis_tvalid;
			for (int k = 2; k <= ST_OUT; k++)
				vld_s[k] <= vld_s[k-1];
		end
	end

	// Item side data, with fields filled in as they are computed.
	carry_t car_s  [1:ST_OUT];
	carry_t car_nx [1:ST_OUT-1];
	carry_t car_in;

	logic [31:0] root_a;
	logic [31:0] root_b;
	logic [54:0] xq;
	logic [54:0] q1;
	logic [54:0] qq;
	logic [30:0] h_c;
	logic [30:0] d_c;
	logic [24:0] e_c;

	always_comb begin
		car_in        = '0;
		car_in.n      = s_axis_tdata[31:0];
		car_in.ta     = s_axis_tdata[63:32];
		car_in.tb     = s_axis_tdata[95:64];
		car_in.om     = s_axis_tdata[126:96];
	end

	always_comb begin
		d_c = (root_a > MAX31) ? MAX31[30:0] : root_a[30:0];
		// Irreversible mode keeps the historical maximum.
		h_c = (irr_q && (car_s[ST_H-1].om > d_c)) ? car_s[ST_H-1].om : d_c;
	end

	always_comb begin
		for (int k = 1; k < ST_OUT; k++)
			car_nx[k] = car_s[k];
		car_nx[ST_H-1].h      = h_c;
		car_nx[ST_H-1].sb     = root_b;
		car_nx[ST_X].f        = {xq[23:0], 6'b0};
		car_nx[ST_X].ipow     = xq[28:24];
		car_nx[ST_X].big      = (|xq[54:29]) || (xq[28:24] >= 5'(EXP_LIMIT));
		car_nx[ST_PWE].damage = ONE_Q24 - e_c;
		// The prefactor saturates when floor(q1 / delta0) reaches 2^31.
		car_nx[ST_Q1].sat     = (31'(q1[54:31]) >= d0_q);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			car_s[1] <= car_in;
			for (int k = 2; k <= ST_OUT; k++)
				car_s[k] <= car_nx[k-1];
		end
	end

	// Effective jump squared: n^2 + floor(beta*(t1^2+t2^2)/2^24) + eps.
	logic [63:0] an2_s1, aa2_s1, ab2_s1;
	logic [63:0] tsq_s2, an2_s2;
	logic [62:0] hp_s3, lp_s3;
	logic [63:0] an2_s3, an2_s4;
	logic [62:0] t_s4, t_c;
	logic [62:0] s_s5, s_c;
	logic [62:0] tr_c;
	logic [64:0] sm_c;

	always_comb begin
		tr_c = 63'({hp_s3[53:0], 8'b0}) + 63'(lp_s3[62:24]);
		if (hp_s3 >= 63'(64'd1 << 54))
			t_c = SUM_CAP;
		else if (tr_c > SUM_CAP)
			t_c = SUM_CAP;
		else
			t_c = tr_c;
		sm_c = 65'(an2_s4) + 65'(t_s4) + 65'({eps_q, 24'b0});
		s_c  = (sm_c > 65'(SUM_CAP)) ? SUM_CAP : sm_c[62:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			an2_s1 <= 64'(abs32(car_in.n)) * 64'(abs32(car_in.n));
			aa2_s1 <= 64'(abs32(car_in.ta)) * 64'(abs32(car_in.ta));
			ab2_s1 <= 64'(abs32(car_in.tb)) * 64'(abs32(car_in.tb));
			tsq_s2 <= aa2_s1 + ab2_s1;
			an2_s2 <= an2_s1;
			hp_s3  <= 63'(tw_q) * 63'(tsq_s2[63:32]);
			lp_s3  <= 63'(tw_q) * 63'(tsq_s2[31:0]);
			an2_s3 <= an2_s2;
			t_s4   <= t_c;
			an2_s4 <= an2_s3;
			s_s5   <= s_c;
		end
	end

	ectl_isqrt u_sqrt_eff (
		.clk  (clk),
		.en   (en),
		.rad  ({1'b0, s_s5}),
		.root (root_a)
	);

	// sqrt(beta) in Q8.24, aligned with the same item.
	ectl_isqrt u_sqrt_beta (
		.clk  (clk),
		.en   (en),
		.rad  ({9'b0, tw_q, 24'b0}),
		.root (root_b)
	);

	// x = floor(h * 2^24 / delta0).
	ectl_div u_div_x (
		.clk     (clk),
		.en      (en),
		.num_top (31'd0),
		.num_low ({car_s[ST_H].h, 24'b0}),
		.den     (d0_q),
		.quo     (xq)
	);

	// exp(-f) by 20 truncating Taylor terms, three stages per term:
	// product with f, reciprocal multiply, then the divide correction and the sum.
	logic [59:0]        tpr_s [1:TAY_TERMS];
	logic signed [32:0] tsa_s [1:TAY_TERMS];
	logic [29:0]        tv_s  [1:TAY_TERMS];
	logic [61:0]        tm_s  [1:TAY_TERMS];
	logic signed [32:0] tsb_s [1:TAY_TERMS];
	logic [30:0]        tt_s  [1:TAY_TERMS];
	logic signed [32:0] tsc_s [1:TAY_TERMS];
	logic [30:0]        tin_c [1:TAY_TERMS];
	logic signed [32:0] sin_c [1:TAY_TERMS];
	logic [30:0]        tq_c  [1:TAY_TERMS];

	always_comb begin
		logic [29:0] q0, rm;
		for (int k = 1; k <= TAY_TERMS; k++) begin
			tin_c[k] = (k == 1) ? ONE_Q30 : tt_s[(k == 1) ? 1 : k-1];
			sin_c[k] = (k == 1) ? 33'sd1073741824 : tsc_s[(k == 1) ? 1 : k-1];
			q0 = tm_s[k][61:32];
			rm = tv_s[k] - 30'(q0 * 30'(k));
			tq_c[k] = (rm >= 30'(k)) ? 31'(q0) + 31'd1 : 31'(q0);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 1; k <= TAY_TERMS; k++) begin
				tpr_s[k] <= 60'(tin_c[k]) * 60'(car_s[ST_TY0+3*k-3].f);
				tsa_s[k] <= sin_c[k];
				tv_s[k]  <= tpr_s[k][59:30];
				tm_s[k]  <= 62'(tpr_s[k][59:30]) * 62'(RECIP[k]);
				tsb_s[k] <= tsa_s[k];
				tt_s[k]  <= tq_c[k];
				if ((k & 1) == 1)
					tsc_s[k] <= tsb_s[k] - 33'(tq_c[k]);
				else
					tsc_s[k] <= tsb_s[k] + 33'(tq_c[k]);
			end
		end
	end

	// Clamp the series to [0, 1.0], then multiply by exp(-1) once per integer unit.
	logic [30:0] cl_s;
	logic [30:0] pw_s  [0:POW_STEPS-1];
	logic [61:0] pwm_c [0:POW_STEPS-1];
	logic [30:0] pin_c [0:POW_STEPS-1];

	always_comb begin
		for (int j = 0; j < POW_STEPS; j++) begin
			pin_c[j] = (j == 0) ? cl_s : pw_s[(j == 0) ? 0 : j-1];
			pwm_c[j] = 62'(pin_c[j]) * 62'(E1_Q30);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (tsc_s[TAY_TERMS] < 0)
				cl_s <= 31'd0;
			else if (tsc_s[TAY_TERMS] > 33'sd1073741824)
				cl_s <= ONE_Q30;
			else
				cl_s <= tsc_s[TAY_TERMS][30:0];
			for (int j = 0; j < POW_STEPS; j++) begin
				if (5'(j) < car_s[ST_CL+j].ipow)
					pw_s[j] <= pwm_c[j][60:30];
				else
					pw_s[j] <= pin_c[j];
			end
		end
	end

	// Round Q2.30 to Q8.24; large x gives exp = 0 and full damage.
	logic [31:0] er_c;
	logic [24:0] e_s173;
	logic [30:0] p_s174;

	always_comb begin
		er_c = (32'(pw_s[POW_STEPS-1]) + 32'd32) >> 6;
		if (car_s[ST_PWE].big)
			e_c = 25'd0;
		else if (er_c > 32'(ONE_Q24))
			e_c = ONE_Q24;
		else
			e_c = er_c[24:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_s173 <= e_c;
			p_s174 <= 31'((56'(e_s173) * 56'(fe_q)) >> 24);
		end
	end

	// q1 = floor(P*2^24/delta0), then q = floor(q1*2^24/delta0).
	ectl_div u_div_q1 (
		.clk     (clk),
		.en      (en),
		.num_top (31'd0),
		.num_low ({p_s174, 24'b0}),
		.den     (d0_q),
		.quo     (q1)
	);

	ectl_div u_div_q (
		.clk     (clk),
		.en      (en),
		.num_top (31'(q1[54:31])),
		.num_low ({q1[30:0], 24'b0}),
		.den     (d0_q),
		.quo     (qq)
	);

	// Scale the jump components by the prefactor and the tangents by sqrt(beta).
	logic [55:0] q_c;
	logic [55:0] hn_s285, ha_s285, hb_s285;
	logic [63:0] ln_s285, la_s285, lb_s285;
	logic [63:0] ea_s285, eb_s285;
	logic [247:0] res_s286;

	assign q_c = car_s[ST_Q].sat ? PREF_CAP : {1'b0, qq};

	always_ff @(posedge clk) begin
		if (en) begin
			hn_s285 <= 56'(abs32(car_s[ST_Q].n)) * 56'(q_c[55:32]);
			ha_s285 <= 56'(abs32(car_s[ST_Q].ta)) * 56'(q_c[55:32]);
			hb_s285 <= 56'(abs32(car_s[ST_Q].tb)) * 56'(q_c[55:32]);
			ln_s285 <= 64'(abs32(car_s[ST_Q].n)) * 64'(q_c[31:0]);
			la_s285 <= 64'(abs32(car_s[ST_Q].ta)) * 64'(q_c[31:0]);
			lb_s285 <= 64'(abs32(car_s[ST_Q].tb)) * 64'(q_c[31:0]);
			ea_s285 <= 64'(abs32(car_s[ST_Q].ta)) * 64'(car_s[ST_Q].sb);
			eb_s285 <= 64'(abs32(car_s[ST_Q].tb)) * 64'(car_s[ST_Q].sb);
			res_s286 <= {
				scale_fin(56'd0, eb_s285, car_s[ST_MUL].tb[31]),
				scale_fin(56'd0, ea_s285, car_s[ST_MUL].ta[31]),
				car_s[ST_MUL].n,
				car_s[ST_MUL].h,
				car_s[ST_MUL].damage,
				scale_fin(hb_s285, lb_s285, car_s[ST_MUL].tb[31]),
				scale_fin(ha_s285, la_s285, car_s[ST_MUL].ta[31]),
				scale_fin(hn_s285, ln_s285, car_s[ST_MUL].n[31])
			};
		end
	end

	assign m_axis_tdata = res_s286;

	// Damage never exceeds one.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[120:96] <= ONE_Q24))
		else $error("damage above one");

	// Full damage leaves no traction.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tdata[120:96] == ONE_Q24)) |->
		((m_axis_tdata[31:0] == 32'd0) && (m_axis_tdata[63:32] == 32'd0) &&
		(m_axis_tdata[95:64] == 32'd0)))
		else $error("traction with full damage");

	// A zero normal jump gives zero normal traction.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tdata[183:152] == 32'd0)) |->
		(m_axis_tdata[31:0] == 32'd0))
		else $error("normal traction without normal jump");

	// The exponential series stays within [0, 1.0] after clamping.
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[ST_CL] |-> (cl_s <= ONE_Q30))
		else $error("series clamp out of range");

endmodule

FILE: hdl/ectl_isqrt.sv
// Pipelined 64-bit integer square root, one result bit per register stage.
// Depends on ectl_pkg for the step count.
module ectl_isqrt import ectl_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] rad,
	output logic [31:0] root
);

	logic [63:0] v_s [0:SQRT_STEPS-1];
	logic [63:0] r_s [0:SQRT_STEPS-1];
	logic [63:0] vn_c [0:SQRT_STEPS-1];
	logic [63:0] rn_c [0:SQRT_STEPS-1];

	always_comb begin
		logic [63:0] vi, ri, bt, tr;
		for (int k = 0; k < SQRT_STEPS; k++) begin
			vi = (k == 0) ? rad : v_s[(k == 0) ? 0 : k-1];
			ri = (k == 0) ? 64'd0 : r_s[(k == 0) ? 0 : k-1];
			bt = 64'd1 << (62 - 2*k);
			tr = ri + bt;
			if (vi >= tr) begin
				vn_c[k] = vi - tr;
				rn_c[k] = (ri >> 1) + bt;
			end else begin
				vn_c[k] = vi;
				rn_c[k] = ri >> 1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < SQRT_STEPS; k++) begin
				v_s[k] <= vn_c[k];
				r_s[k] <= rn_c[k];
			end
		end
	end

	assign root = r_s[SQRT_STEPS-1][31:0];

endmodule

FILE: hdl/ectl_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// The upper dividend part must be below the divisor; depends on ectl_pkg.
module ectl_div import ectl_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [30:0] num_top,
	input  logic [54:0] num_low,
	input  logic [30:0] den,
	output logic [54:0] quo
);

	logic [30:0] rem_s [0:DIV_STEPS-1];
	logic [54:0] acc_s [0:DIV_STEPS-1];
	logic [30:0] rn_c  [0:DIV_STEPS-1];
	logic [54:0] an_c  [0:DIV_STEPS-1];

	always_comb begin
		logic [30:0] ri;
		logic [54:0] ai;
		logic [31:0] tr;
		logic        b;
		for (int k = 0; k < DIV_STEPS; k++) begin
			ri = (k == 0) ? num_top : rem_s[(k == 0) ? 0 : k-1];
			ai = (k == 0) ? num_low : acc_s[(k == 0) ? 0 : k-1];
			tr = {ri, ai[54]};
			b  = (tr >= {1'b0, den});
			rn_c[k] = b ? 31'(tr - {1'b0, den}) : tr[30:0];
			an_c[k] = {ai[53:0], b};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < DIV_STEPS; k++) begin
				rem_s[k] <= rn_c[k];
				acc_s[k] <= an_c[k];
			end
		end
	end

	assign quo = acc_s[DIV_STEPS-1];

endmodule
